@@ hw/rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  typedef logic [31:0] word_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;   // copy chain value into working variables
    logic       round;  // run one round
    logic [5:0] t;      // round number
    logic       fold;   // add working variables into chain value
    logic       init;   // restore initial hash values
  } rnd_ctrl_t;

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

@@ hw/rtl/sha256_buf.sv @@
// ----------------------------------------------------------------------------
// SHA-256 block buffer
// 16 x 32-bit memory that holds one block; written a byte lane at a time,
// read one word at a time through a registered output.
// ----------------------------------------------------------------------------
module sha256_buf
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_byte,
  input  logic [3:0] rd_addr,
  output word_t      rd_word
);

  logic [7:0] mem0 [16];
  logic [7:0] mem1 [16];
  logic [7:0] mem2 [16];
  logic [7:0] mem3 [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_addr[1:0])
        2'd0: mem0[wr_addr[5:2]] <= wr_byte;
        2'd1: mem1[wr_addr[5:2]] <= wr_byte;
        2'd2: mem2[wr_addr[5:2]] <= wr_byte;
        default: mem3[wr_addr[5:2]] <= wr_byte;
      endcase
    end
    rd_word <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
  end

endmodule

@@ hw/rtl/sha256_rnd.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables, rolling message schedule and chaining value; one
// round per cycle while the round control is set.
// ----------------------------------------------------------------------------
module sha256_rnd
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rnd_ctrl_t ctrl,
  input  word_t     blk_word,
  input  logic [2:0] hash_sel,
  output word_t     hash_word
);

  word_t a, b, c, d, e, f, g, h;
  word_t w [16];
  word_t chain [8];
  word_t wt, t1, t2;

  always_comb begin
    if (ctrl.t < 6'd16) begin
      wt = blk_word;
    end else begin
      wt = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
    end
    t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + ROUND_K[ctrl.t] + wt;
    t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
    end else if (ctrl.round) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else if (ctrl.fold) begin
      chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e; chain[5] <= chain[5] + f;
      chain[6] <= chain[6] + g; chain[7] <= chain[7] + h;
    end
  end

  assign hash_word = chain[hash_sel];

endmodule

@@ hw/rtl/sha256_byte_stream_hasher_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs at most one byte per transaction, pads at message end and emits the digest.
// ----------------------------------------------------------------------------
// A byte that neither completes a block nor ends the message leaves the
// input ready. The byte that completes a block, and each padding block, holds
// the input through a buffer read, the rounds through the single round unit
// and a fold. At message end the padding is written into the block buffer
// one byte a cycle, then the digest words leave as eight transactions, index
// 0 first.
module sha256_byte_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        m_tlast    // last_word
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_FOLD  = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [5:0] fill;
  logic [63:0] msg_bits;
  logic [6:0] rnd;       // round counter, also pad byte pointer
  logic       at_end;    // padding in progress
  logic       len_done;  // current padding block carries the length
  logic [2:0] out_idx;
  logic       fold_last;
  rnd_ctrl_t  ctrl;
  word_t      blk_word, hash_word;
  logic       wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_byte, pad_byte;
  logic       acc, present;

  assign acc     = s_tvalid && s_tready;
  assign present = s_tuser;
  assign s_tready = (state == ST_IDLE);

  // Padding byte at pointer position of the current padding block.
  always_comb begin
    pad_byte = 8'h00;
    if (rnd[5:0] >= LEN_START && len_done) begin
      pad_byte = msg_bits[8*(7 - rnd[2:0]) +: 8];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill;
    wr_byte = s_tdata;
    if (acc && present) begin
      wr_en = 1'b1;
    end else if (state == ST_PAD) begin
      wr_en   = 1'b1;
      wr_addr = rnd[5:0];
      wr_byte = (rnd[5:0] == fill && !fold_last) ? PAD_BYTE : pad_byte;
    end
  end

  sha256_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_byte (wr_byte),
    .rd_addr (state == ST_LOAD ? 4'd0 : 4'(rnd[3:0] + 4'd1)),
    .rd_word (blk_word)
  );

  always_comb begin
    ctrl.load  = (state == ST_LOAD);
    ctrl.round = (state == ST_ROUND);
    ctrl.t     = rnd[5:0];
    ctrl.fold  = (state == ST_FOLD);
    ctrl.init  = (state == ST_OUT) && m_tready && (out_idx == 3'd7);
  end

  sha256_rnd u_rnd (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .blk_word  (blk_word),
    .hash_sel  (out_idx),
    .hash_word (hash_word)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (present && fill == 6'd63) state_next = ST_LOAD;
          else if (s_tlast) state_next = ST_PAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (rnd[5:0] == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!at_end) state_next = ST_IDLE;
        else if (len_done) state_next = ST_OUT;
        else state_next = ST_PAD;
      end
      ST_PAD:   if (rnd[5:0] == 6'd63) state_next = ST_LOAD;
      ST_OUT:   if (m_tready && out_idx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      msg_bits <= '0;
      rnd      <= '0;
      at_end   <= 1'b0;
      len_done <= 1'b0;
      out_idx  <= '0;
      fold_last <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            // Padding starts right after the last byte of the message.
            rnd <= {1'b0, (present ? fill + 6'd1 : fill)};
            if (present) begin
              fill     <= fill + 6'd1;
              msg_bits <= msg_bits + 64'd8;
            end
            at_end    <= s_tlast;
            fold_last <= 1'b0;
            // Length fits in this block when the 0x80 lands before byte 56.
            len_done  <= ((present ? fill + 6'd1 : fill) < LEN_START)
                         && !(present && fill == 6'd63);
          end else begin
            rnd <= '0;
          end
        end
        ST_LOAD:  rnd <= '0;
        ST_ROUND: rnd <= rnd + 7'd1;
        ST_FOLD: begin
          rnd <= '0;
          if (at_end && !len_done) begin
            // Full block done with end pending: the 0x80 goes at fill.
            len_done <= (fold_last || fill == 6'd0) ? 1'b1 : 1'b0;
          end else if (at_end) begin
            fold_last <= 1'b1;
          end
        end
        ST_PAD: begin
          rnd <= rnd + 7'd1;
          if (rnd[5:0] == 6'd63) begin
            if (!len_done) begin
              fold_last <= 1'b1;
              len_done  <= 1'b0;
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              fill     <= '0;
              msg_bits <= '0;
              at_end   <= 1'b0;
              fold_last <= 1'b0;
              len_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'd0, out_idx, hash_word};
  assign m_tlast  = (out_idx == 3'd7);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input ready while digest pending");
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("digest burst broken");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_ROUND && rnd == 7'd0))
    else $error("round sequence out of step");

endmodule
